>>> hw/rtl/tlpc_pkg.sv
`timescale 1ns / 1ps

package tlpc_pkg;

  localparam int unsigned DUR_W    = 8;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DUR_W-1:0]   GREEN_RESET  = DUR_W'(30);
  localparam logic [DUR_W-1:0]   YELLOW_RESET = DUR_W'(5);
  localparam logic [DUR_W-1:0]   RED_RESET    = DUR_W'(30);
  localparam logic [COUNT_W-1:0] ALERT_LIMIT  = COUNT_W'(2);

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RED    = CFG_IDX_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK       = 3'd0,
    FUNC_ACTIVATE   = 3'd1,
    FUNC_DEACTIVATE = 3'd2,
    FUNC_EMERG_ON   = 3'd3,
    FUNC_EMERG_OFF  = 3'd4,
    FUNC_REPORT     = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    LIGHT_RED    = 2'd0,
    LIGHT_YELLOW = 2'd1,
    LIGHT_GREEN  = 2'd2
  } light_t;

  typedef struct packed {
    logic [DUR_W-1:0] green;
    logic [DUR_W-1:0] yellow;
    logic [DUR_W-1:0] red;
  } durations_t;

  typedef struct packed {
    light_t           light;
    logic [DUR_W-1:0] ticks;
    logic             active;
    logic             emergency;
  } ctrl_state_t;

  typedef struct packed {
    light_t light;
    logic   enabled;
    logic   emergency;
    logic   alert;
    logic   accepted;
  } result_t;

endpackage

>>> hw/rtl/tlpc_cfg_regs.sv
`timescale 1ns / 1ps

module tlpc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlpc_pkg::DUR_W-1:0]         cfg_wdata,
  output tlpc_pkg::durations_t               durations
);

  always_ff @(posedge clk) begin
    if (rst) begin
      durations.green  <= tlpc_pkg::GREEN_RESET;
      durations.yellow <= tlpc_pkg::YELLOW_RESET;
      durations.red    <= tlpc_pkg::RED_RESET;
    end else if (cfg_we) begin
      // index beyond the map is dropped
      if (cfg_index == tlpc_pkg::REG_GREEN) begin
        durations.green <= cfg_wdata;
      end
      if (cfg_index == tlpc_pkg::REG_YELLOW) begin
        durations.yellow <= cfg_wdata;
      end
      if (cfg_index == tlpc_pkg::REG_RED) begin
        durations.red <= cfg_wdata;
      end
    end
  end

endmodule

>>> hw/rtl/tlpc_step.sv
`timescale 1ns / 1ps

module tlpc_step (
  input  tlpc_pkg::ctrl_state_t            state,
  input  tlpc_pkg::durations_t             durations,
  input  logic [tlpc_pkg::FUNC_W-1:0]      func,
  input  logic [tlpc_pkg::COUNT_W-1:0]     vehicle_count,
  output tlpc_pkg::ctrl_state_t            state_next,
  output tlpc_pkg::result_t                result
);

  logic [tlpc_pkg::DUR_W-1:0] dur_raw;
  logic [tlpc_pkg::DUR_W-1:0] dur;
  logic [tlpc_pkg::DUR_W:0]   ticks_inc;
  logic                       phase_done;
  logic                       alert;
  logic                       accepted;

  always_comb begin
    unique case (state.light)
      tlpc_pkg::LIGHT_GREEN:  dur_raw = durations.green;
      tlpc_pkg::LIGHT_YELLOW: dur_raw = durations.yellow;
      default:                dur_raw = durations.red;
    endcase
  end

  // zero duration behaves as a single tick
  assign dur        = (dur_raw == '0) ? tlpc_pkg::DUR_W'(1) : dur_raw;
  assign ticks_inc  = {1'b0, state.ticks} + (tlpc_pkg::DUR_W + 1)'(1);
  assign phase_done = ticks_inc >= {1'b0, dur};

  always_comb begin
    state_next = state;
    alert      = 1'b0;
    accepted   = 1'b1;
    case (tlpc_pkg::func_t'(func))
      tlpc_pkg::FUNC_TICK: begin
        if (state.active) begin
          if (state.emergency) begin
            state_next.light = (state.light == tlpc_pkg::LIGHT_YELLOW) ?
                               tlpc_pkg::LIGHT_RED : tlpc_pkg::LIGHT_YELLOW;
            state_next.ticks = '0;
          end else if (phase_done) begin
            unique case (state.light)
              tlpc_pkg::LIGHT_GREEN:  state_next.light = tlpc_pkg::LIGHT_YELLOW;
              tlpc_pkg::LIGHT_YELLOW: state_next.light = tlpc_pkg::LIGHT_RED;
              default:                state_next.light = tlpc_pkg::LIGHT_GREEN;
            endcase
            state_next.ticks = '0;
          end else begin
            state_next.ticks = ticks_inc[tlpc_pkg::DUR_W-1:0];
          end
        end
      end
      tlpc_pkg::FUNC_ACTIVATE: begin
        state_next.active    = 1'b1;
        state_next.emergency = 1'b0;
        state_next.light     = tlpc_pkg::LIGHT_GREEN;
        state_next.ticks     = '0;
      end
      tlpc_pkg::FUNC_DEACTIVATE: begin
        state_next.active = 1'b0;
      end
      tlpc_pkg::FUNC_EMERG_ON: begin
        state_next.emergency = 1'b1;
        state_next.light     = tlpc_pkg::LIGHT_YELLOW;
        state_next.ticks     = '0;
      end
      tlpc_pkg::FUNC_EMERG_OFF: begin
        state_next.emergency = 1'b0;
        state_next.light     = tlpc_pkg::LIGHT_GREEN;
        state_next.ticks     = '0;
      end
      tlpc_pkg::FUNC_REPORT: begin
        alert = (state.light == tlpc_pkg::LIGHT_RED) &&
                (vehicle_count > tlpc_pkg::ALERT_LIMIT);
      end
      default: begin
        accepted = 1'b0;
      end
    endcase
  end

  assign result.light     = state_next.light;
  assign result.enabled   = state_next.active;
  assign result.emergency = state_next.emergency;
  assign result.alert     = alert;
  assign result.accepted  = accepted;

endmodule

>>> hw/rtl/traffic_light_phase_controller.sv
`timescale 1ns / 1ps
// An accepted input transaction reaches m_axis through the input register, then the
//   result register; an output stall holds it in the input register.
// Throughput: one transaction per cycle while the output is not stalled; the phase
//   update is a single compare-and-increment between the two registers.
// Reset (rst, synchronous): green, ticks 0, active, no emergency, durations 30/5/30.
module traffic_light_phase_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] vehicle_count
  input  logic [2:0]  s_axis_tuser,   // [2:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [1:0] light, [2] enabled, [3] emergency,
                                      // [4] violation_alert, [5] accepted, [7:6] zero
);

  tlpc_pkg::durations_t  durations;
  tlpc_pkg::ctrl_state_t state;
  tlpc_pkg::ctrl_state_t state_next;
  tlpc_pkg::result_t     result;
  tlpc_pkg::result_t     out_res;

  logic                           in_valid;
  logic [tlpc_pkg::FUNC_W-1:0]    in_func;
  logic [tlpc_pkg::COUNT_W-1:0]   in_count;
  logic                           advance;

  tlpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .durations (durations)
  );

  tlpc_step u_step (
    .state         (state),
    .durations     (durations),
    .func          (in_func),
    .vehicle_count (in_count),
    .state_next    (state_next),
    .result        (result)
  );

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func  <= s_axis_tuser;
      in_count <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.light     <= tlpc_pkg::LIGHT_GREEN;
      state.ticks     <= '0;
      state.active    <= 1'b1;
      state.emergency <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.accepted, out_res.alert, out_res.emergency,
                         out_res.enabled, out_res.light};

endmodule

>>> hw/rtl/tlpc_checker.sv
`timescale 1ns / 1ps

module tlpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // held result transaction must not change under backpressure
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  a_light_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("light code out of range");

  // an alert only comes from an accepted report while red
  a_alert_red: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[5] && m_axis_tdata[1:0] == 2'd0)
    else $error("alert without red light");

  // flashing mode only ever shows yellow or red
  a_emerg_light: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[1:0] != 2'd2)
    else $error("green shown in emergency mode");

endmodule

bind traffic_light_phase_controller tlpc_checker u_tlpc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [tlpc_pkg::CFG_IDX_W-1:0] REG_SPARE =
    tlpc_pkg::CFG_IDX_W'(3);  // unmapped, writes dropped
  localparam logic [tlpc_pkg::FUNC_W-1:0] FUNC_RSVD_A = 3'd6;
  localparam logic [tlpc_pkg::FUNC_W-1:0] FUNC_RSVD_B = 3'd7;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PLAN_LEN       = 25;
  localparam int N_SETTINGS     = 6;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] vehicle_count
  logic [2:0] s_axis_tuser;   // [2:0] func
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [1:0] light, [2] enabled, [3] emergency,
                              // [4] violation_alert, [5] accepted, [7:6] zero

  traffic_light_phase_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // controller state as the predictor sees it
  tlpc_pkg::durations_t dur;
  tlpc_pkg::light_t     lamp;
  logic [7:0] held_ticks;
  logic       running;
  logic       flashing;

  tlpc_pkg::result_t results_due[$];
  int unsigned mismatches = 0;
  int unsigned stalled_cycles = 0;
  bit          source_calm;

  typedef struct {
    logic [2:0]       func;
    logic [7:0]       count;
    bit               fixed;    // expected result typed into the row
    tlpc_pkg::light_t light;
    bit               enabled;
    bit               emergency;
    bit               alert;
    bit               accepted;
  } plan_row_t;

  // from reset: green, active, no emergency
  plan_row_t plan [PLAN_LEN] = '{
    '{FUNC_RSVD_A,               8'd0,   1, tlpc_pkg::LIGHT_GREEN,  1, 0, 0, 0},
    '{FUNC_RSVD_B,               8'd255, 1, tlpc_pkg::LIGHT_GREEN,  1, 0, 0, 0},
    '{tlpc_pkg::FUNC_REPORT,     8'd255, 1, tlpc_pkg::LIGHT_GREEN,  1, 0, 0, 1},
    '{tlpc_pkg::FUNC_TICK,       8'd255, 1, tlpc_pkg::LIGHT_GREEN,  1, 0, 0, 1},
    '{tlpc_pkg::FUNC_EMERG_ON,   8'd0,   1, tlpc_pkg::LIGHT_YELLOW, 1, 1, 0, 1},
    '{tlpc_pkg::FUNC_REPORT,     8'd3,   1, tlpc_pkg::LIGHT_YELLOW, 1, 1, 0, 1},
    '{tlpc_pkg::FUNC_TICK,       8'd0,   1, tlpc_pkg::LIGHT_RED,    1, 1, 0, 1},
    '{tlpc_pkg::FUNC_REPORT,     8'd3,   1, tlpc_pkg::LIGHT_RED,    1, 1, 1, 1},
    '{tlpc_pkg::FUNC_REPORT,     8'd2,   1, tlpc_pkg::LIGHT_RED,    1, 1, 0, 1},
    '{tlpc_pkg::FUNC_REPORT,     8'd255, 1, tlpc_pkg::LIGHT_RED,    1, 1, 1, 1},
    '{tlpc_pkg::FUNC_REPORT,     8'd0,   1, tlpc_pkg::LIGHT_RED,    1, 1, 0, 1},
    '{tlpc_pkg::FUNC_TICK,       8'd7,   1, tlpc_pkg::LIGHT_YELLOW, 1, 1, 0, 1},
    '{tlpc_pkg::FUNC_TICK,       8'd0,   1, tlpc_pkg::LIGHT_RED,    1, 1, 0, 1},
    '{tlpc_pkg::FUNC_DEACTIVATE, 8'd0,   1, tlpc_pkg::LIGHT_RED,    0, 1, 0, 1},
    '{tlpc_pkg::FUNC_TICK,       8'd255, 1, tlpc_pkg::LIGHT_RED,    0, 1, 0, 1},
    '{tlpc_pkg::FUNC_REPORT,     8'd170, 1, tlpc_pkg::LIGHT_RED,    0, 1, 1, 1},
    '{tlpc_pkg::FUNC_REPORT,     8'd85,  1, tlpc_pkg::LIGHT_RED,    0, 1, 1, 1},
    '{tlpc_pkg::FUNC_EMERG_ON,   8'd0,   1, tlpc_pkg::LIGHT_YELLOW, 0, 1, 0, 1},
    '{tlpc_pkg::FUNC_EMERG_OFF,  8'd0,   1, tlpc_pkg::LIGHT_GREEN,  0, 0, 0, 1},
    '{tlpc_pkg::FUNC_EMERG_OFF,  8'd0,   1, tlpc_pkg::LIGHT_GREEN,  0, 0, 0, 1},
    '{tlpc_pkg::FUNC_ACTIVATE,   8'd0,   1, tlpc_pkg::LIGHT_GREEN,  1, 0, 0, 1},
    '{tlpc_pkg::FUNC_EMERG_ON,   8'd0,   1, tlpc_pkg::LIGHT_YELLOW, 1, 1, 0, 1},
    '{tlpc_pkg::FUNC_EMERG_ON,   8'd0,   1, tlpc_pkg::LIGHT_YELLOW, 1, 1, 0, 1},
    '{tlpc_pkg::FUNC_ACTIVATE,   8'd0,   1, tlpc_pkg::LIGHT_GREEN,  1, 0, 0, 1},
    '{tlpc_pkg::FUNC_TICK,       8'd0,   0, tlpc_pkg::LIGHT_RED,    0, 0, 0, 0}
  };

  typedef struct {
    logic [7:0] green;
    logic [7:0] yellow;
    logic [7:0] red;
    int         lead_ticks;   // activate, then this many ticks
    int         items;
  } setting_t;

  // the long-phase setting leaves red part-way through, the next one shortens red
  setting_t settings [N_SETTINGS] = '{
    '{8'd1,   8'd1,   8'd1,   0,   150},
    '{8'd0,   8'd0,   8'd0,   0,   120},
    '{8'd3,   8'd2,   8'd4,   0,   200},
    '{8'd255, 8'd255, 8'd255, 520, 0},
    '{8'd2,   8'd1,   8'd3,   0,   150},
    '{8'd0,   8'd255, 8'd1,   0,   100}
  };

  function automatic logic [8:0] phase_len(tlpc_pkg::light_t l);
    logic [7:0] d;
    case (l)
      tlpc_pkg::LIGHT_GREEN:  d = dur.green;
      tlpc_pkg::LIGHT_YELLOW: d = dur.yellow;
      default:                d = dur.red;
    endcase
    return (d == 8'd0) ? 9'd1 : {1'b0, d};
  endfunction

  task automatic set_duration(input logic [1:0] idx, input logic [7:0] val);
    case (idx)
      tlpc_pkg::REG_GREEN:  dur.green = val;
      tlpc_pkg::REG_YELLOW: dur.yellow = val;
      tlpc_pkg::REG_RED:    dur.red = val;
      default: ;
    endcase
  endtask

  task automatic step_controller(input logic [2:0] f, input logic [7:0] cnt,
                                 output tlpc_pkg::result_t res);
    res = '0;
    res.accepted = 1'b1;
    case (f)
      tlpc_pkg::FUNC_TICK: begin
        if (running) begin
          if (flashing) begin
            lamp = (lamp == tlpc_pkg::LIGHT_YELLOW) ? tlpc_pkg::LIGHT_RED :
                                                      tlpc_pkg::LIGHT_YELLOW;
            held_ticks = '0;
          end else if ({1'b0, held_ticks} + 9'd1 >= phase_len(lamp)) begin
            case (lamp)
              tlpc_pkg::LIGHT_GREEN:  lamp = tlpc_pkg::LIGHT_YELLOW;
              tlpc_pkg::LIGHT_YELLOW: lamp = tlpc_pkg::LIGHT_RED;
              default:                lamp = tlpc_pkg::LIGHT_GREEN;
            endcase
            held_ticks = '0;
          end else begin
            held_ticks = held_ticks + 8'd1;
          end
        end
      end
      tlpc_pkg::FUNC_ACTIVATE: begin
        running = 1'b1;
        flashing = 1'b0;
        lamp = tlpc_pkg::LIGHT_GREEN;
        held_ticks = '0;
      end
      tlpc_pkg::FUNC_DEACTIVATE: running = 1'b0;
      tlpc_pkg::FUNC_EMERG_ON: begin
        flashing = 1'b1;
        lamp = tlpc_pkg::LIGHT_YELLOW;
        held_ticks = '0;
      end
      tlpc_pkg::FUNC_EMERG_OFF: begin
        flashing = 1'b0;
        lamp = tlpc_pkg::LIGHT_GREEN;
        held_ticks = '0;
      end
      tlpc_pkg::FUNC_REPORT:
        res.alert = (lamp == tlpc_pkg::LIGHT_RED) && (cnt > tlpc_pkg::ALERT_LIMIT);
      default: res.accepted = 1'b0;
    endcase
    res.light = lamp;
    res.enabled = running;
    res.emergency = flashing;
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // mostly back-to-back, now and then a short or a long gap
  function automatic int unsigned pick_gap(input bit calm);
    if (calm || $urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(input logic [2:0] f, input logic [7:0] cnt,
                           input bit fixed, input tlpc_pkg::result_t typed);
    tlpc_pkg::result_t due;
    int unsigned       idle;
    idle = pick_gap(source_calm);
    if (idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= cnt;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    step_controller(f, cnt, due);
    results_due.push_back(fixed ? typed : due);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [2:0]  f;
    logic [7:0]  cnt;
    pick = $urandom_range(0, 99);
    if (pick < 62)      f = tlpc_pkg::FUNC_TICK;
    else if (pick < 80) f = tlpc_pkg::FUNC_REPORT;
    else if (pick < 85) f = tlpc_pkg::FUNC_ACTIVATE;
    else if (pick < 88) f = tlpc_pkg::FUNC_DEACTIVATE;
    else if (pick < 92) f = tlpc_pkg::FUNC_EMERG_ON;
    else if (pick < 96) f = tlpc_pkg::FUNC_EMERG_OFF;
    else                f = ($urandom_range(0, 1) != 0) ? FUNC_RSVD_A : FUNC_RSVD_B;
    // counts near the alert threshold half the time
    cnt = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom);
    send_item(f, cnt, 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    set_duration(idx, val);
  endtask

  initial begin
    tlpc_pkg::result_t typed;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    dur.green  = tlpc_pkg::GREEN_RESET;
    dur.yellow = tlpc_pkg::YELLOW_RESET;
    dur.red    = tlpc_pkg::RED_RESET;
    lamp       = tlpc_pkg::LIGHT_GREEN;
    held_ticks = '0;
    running    = 1'b1;
    flashing   = 1'b0;
    source_calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      typed.light     = plan[i].light;
      typed.enabled   = plan[i].enabled;
      typed.emergency = plan[i].emergency;
      typed.alert     = plan[i].alert;
      typed.accepted  = plan[i].accepted;
      send_item(plan[i].func, plan[i].count, plan[i].fixed, typed);
    end

    for (int p = 0; p < N_SETTINGS; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      write_reg(REG_SPARE, 8'($urandom));
      write_reg(tlpc_pkg::REG_GREEN, settings[p].green);
      write_reg(tlpc_pkg::REG_YELLOW, settings[p].yellow);
      write_reg(tlpc_pkg::REG_RED, settings[p].red);
      cfg_we <= 1'b0;
      source_calm = ($urandom_range(0, 3) == 0);
      if (settings[p].lead_ticks != 0) begin
        send_item(tlpc_pkg::FUNC_ACTIVATE, 8'($urandom), 1'b0, '0);
        repeat (settings[p].lead_ticks)
          send_item(tlpc_pkg::FUNC_TICK, 8'($urandom), 1'b0, '0);
      end
      repeat (settings[p].items) send_random();
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side backpressure, with occasional stretches held ready
  initial begin
    int unsigned roll;
    m_axis_tready = 1'b0;
    forever begin
      roll = $urandom_range(0, 199);
      if (roll == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else if (roll < 50) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
          @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    tlpc_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("result 0x%02h with nothing expected", m_axis_tdata));
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata[1:0] !== want.light)
          flag_mismatch($sformatf("light got %0d, want %0d", m_axis_tdata[1:0], want.light));
        if (m_axis_tdata[2] !== want.enabled)
          flag_mismatch($sformatf("enabled got %b, want %b", m_axis_tdata[2], want.enabled));
        if (m_axis_tdata[3] !== want.emergency)
          flag_mismatch($sformatf("emergency got %b, want %b", m_axis_tdata[3],
                                  want.emergency));
        if (m_axis_tdata[4] !== want.alert)
          flag_mismatch($sformatf("violation_alert got %b, want %b", m_axis_tdata[4],
                                  want.alert));
        if (m_axis_tdata[5] !== want.accepted)
          flag_mismatch($sformatf("accepted got %b, want %b", m_axis_tdata[5], want.accepted));
        if (m_axis_tdata[7:6] !== 2'b00)
          flag_mismatch($sformatf("pad bits got %b", m_axis_tdata[7:6]));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

>>> traffic_light_phase_controller.f
hw/rtl/tlpc_pkg.sv
hw/rtl/tlpc_cfg_regs.sv
hw/rtl/tlpc_step.sv
hw/rtl/traffic_light_phase_controller.sv
hw/rtl/tlpc_checker.sv
dv/tb_top.sv
